[rtl/core/socks_command_header_parser_defines.svh]
// Assertion macros for the SOCKS command header parser RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SOCKS_COMMAND_HEADER_PARSER_DEFINES_SVH
`define SOCKS_COMMAND_HEADER_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define SCH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sch assertion failed");

// Next-cycle implication, disabled during reset
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sch assertion failed");

`else

`define SCH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/sch_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sch_pkg;

  // One input byte and its end-of-message mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sch_item_t;

  // One classified byte
  typedef struct packed {
    logic [3:0] role;
    logic [7:0] value;
    logic [7:0] addr_index;
    logic       message_done;
    logic [1:0] status;
  } sch_result_t;

  // Field roles
  localparam logic [3:0] ROLE_VERSION    = 4'd0;
  localparam logic [3:0] ROLE_COMMAND    = 4'd1;
  localparam logic [3:0] ROLE_RESERVED   = 4'd2;
  localparam logic [3:0] ROLE_ADDR_TYPE  = 4'd3;
  localparam logic [3:0] ROLE_DOMAIN_LEN = 4'd4;
  localparam logic [3:0] ROLE_ADDR_BYTE  = 4'd5;
  localparam logic [3:0] ROLE_PORT_HI    = 4'd6;
  localparam logic [3:0] ROLE_PORT_LO    = 4'd7;
  localparam logic [3:0] ROLE_TRAILING   = 4'd8;

  // Message status
  localparam logic [1:0] STATUS_IN_PROGRESS = 2'd0;
  localparam logic [1:0] STATUS_COMPLETE    = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED   = 2'd2;

  // Address type codes
  localparam logic [7:0] ATYP_IPV4   = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN = 8'd3;
  localparam logic [7:0] ATYP_IPV6   = 8'd4;

  // Address lengths
  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  // Byte positions
  localparam logic [8:0] POS_ADDR_TYPE    = 9'd3;
  localparam logic [8:0] POS_ADDR_START   = 9'd4;
  localparam logic [8:0] POS_DOMAIN_START = 9'd5;
  localparam logic [8:0] POS_MAX          = 9'd511;

  // Length thresholds for completeness
  localparam logic [9:0] MIN_MESSAGE     = 10'd7;
  localparam logic [9:0] FIXED_HEAD_LEN  = 10'd6;
  localparam logic [9:0] DOMAIN_HEAD_LEN = 10'd7;

endpackage

`default_nettype wire

[rtl/core/sch_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module sch_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sch_pkg::sch_item_t in_item,
  output logic                   item_valid,
  input  wire logic              item_take,
  output sch_pkg::sch_item_t     item
);
  import sch_pkg::*;

  logic      valid_r;
  sch_item_t item_r;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Hold the accepted byte until decode takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sch_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "socks_command_header_parser_defines.svh"

module sch_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire sch_pkg::sch_item_t item,
  output sch_pkg::sch_result_t    res
);
  import sch_pkg::*;

  logic [8:0] pos_r, pos_nxt;
  logic [7:0] atyp_r, atyp_nxt;
  logic [7:0] alen_r, alen_nxt;

  logic       is_ip;
  logic       is_domain;
  logic       addr_known;
  logic [8:0] addr_start;
  logic [8:0] offset;
  logic [9:0] count;
  logic [9:0] need;
  logic       complete;
  logic       nxt_is_ip;
  logic       nxt_is_domain;

  // Classify the byte against the current position and kept address info
  always_comb begin
    res.role         = ROLE_TRAILING;
    res.value        = item.data_byte;
    res.addr_index   = 8'd0;
    res.message_done = item.last_byte;
    atyp_nxt         = atyp_r;
    alen_nxt         = alen_r;

    is_ip      = (atyp_r == ATYP_IPV4) || (atyp_r == ATYP_IPV6);
    is_domain  = (atyp_r == ATYP_DOMAIN);
    addr_start = is_domain ? POS_DOMAIN_START : POS_ADDR_START;
    offset     = pos_r - addr_start;
    addr_known = 1'b0;

    if (pos_r < POS_ADDR_START) begin
      res.role = 4'(pos_r);
      if (pos_r == POS_ADDR_TYPE) begin
        atyp_nxt = item.data_byte;
        if (item.data_byte == ATYP_IPV4) begin
          alen_nxt = IPV4_LEN;
        end else if (item.data_byte == ATYP_IPV6) begin
          alen_nxt = IPV6_LEN;
        end else begin
          alen_nxt = 8'd0;
        end
      end
    end else begin
      addr_known = is_ip || (is_domain && (pos_r != POS_ADDR_START));
      if (is_domain && (pos_r == POS_ADDR_START)) begin
        res.role = ROLE_DOMAIN_LEN;
        alen_nxt = item.data_byte;
      end
      if (addr_known) begin
        if (offset < {1'b0, alen_r}) begin
          res.role       = ROLE_ADDR_BYTE;
          res.addr_index = offset[7:0];
        end else if (offset == {1'b0, alen_r}) begin
          res.role = ROLE_PORT_HI;
        end else if (offset == ({1'b0, alen_r} + 9'd1)) begin
          res.role = ROLE_PORT_LO;
        end else begin
          res.role = ROLE_TRAILING;
        end
      end
    end

    // Judge completeness from the updated address type and length
    nxt_is_ip     = (atyp_nxt == ATYP_IPV4) || (atyp_nxt == ATYP_IPV6);
    nxt_is_domain = (atyp_nxt == ATYP_DOMAIN);
    count         = {1'b0, pos_r} + 10'd1;
    need          = MIN_MESSAGE;
    complete      = 1'b0;
    if (pos_r >= POS_ADDR_TYPE) begin
      if (nxt_is_ip) begin
        need = FIXED_HEAD_LEN + {2'b00, alen_nxt};
      end else if (nxt_is_domain) begin
        need = DOMAIN_HEAD_LEN + {2'b00, alen_nxt};
      end
    end
    if (nxt_is_domain && (pos_r == POS_ADDR_TYPE)) begin
      complete = 1'b0;
    end else begin
      complete = (count >= need);
    end

    if (!item.last_byte) begin
      res.status = STATUS_IN_PROGRESS;
    end else if (complete) begin
      res.status = STATUS_COMPLETE;
    end else begin
      res.status = STATUS_TRUNCATED;
    end

    if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 9'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  // Advance parser state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 9'd0;
      atyp_r <= 8'd0;
      alen_r <= 8'd0;
    end else if (advance) begin
      if (item.last_byte) begin
        pos_r  <= 9'd0;
        atyp_r <= 8'd0;
        alen_r <= 8'd0;
      end else begin
        pos_r  <= pos_nxt;
        atyp_r <= atyp_nxt;
        alen_r <= alen_nxt;
      end
    end
  end

  `SCH_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && item.last_byte,
    (pos_r == 9'd0) && (atyp_r == 8'd0) && (alen_r == 8'd0))
  `SCH_ASSERT_NEXT(a_pos_steps, clk, rst_n,
    advance && !item.last_byte && (pos_r != POS_MAX),
    pos_r == 9'($past(pos_r) + 9'd1))
  `SCH_ASSERT_IMPL(a_index_in_range, clk, rst_n, res.role == ROLE_ADDR_BYTE,
    res.addr_index < alen_r)

endmodule

`default_nettype wire

[rtl/core/sch_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module sch_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 res_valid,
  output logic                      res_ready,
  input  wire sch_pkg::sch_result_t res,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sch_pkg::sch_result_t      out_res
);
  import sch_pkg::*;

  logic        valid_r;
  sch_result_t res_r;

  // Load when empty or when the held result is taken this cycle
  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  // Hold the result until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/core/socks_command_header_parser.sv]
// SOCKS5 command request/reply header parser.
// Input channel (in_valid/in_ready): one message byte per transfer with
// in_last_byte marking the final byte. Output channel (out_valid/out_ready):
// one result per input byte, naming the byte's field (version, command,
// reserved, address type, domain length, address byte with index, port
// high/low, trailing), the byte itself, and on the final byte whether the
// message was complete or truncated.
// An accepted byte is registered in the input register, classified by the
// combinational decode stage as it moves into the output register, and
// shown on the out_ ports from then on. Throughput: one byte per cycle
// while out_ready stays high; each register holds one byte, so a new byte
// enters as the last one moves on.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the first byte of a message; it needs no clearing pass.
// When the receiver stalls, the result holds in the output register, one
// more byte waits in the input register, and in_ready then drops until the
// output moves. The parser also restarts itself after every final byte.
`timescale 1ns / 1ps
`default_nettype none

module socks_command_header_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_role,
  output logic [7:0]      out_value,
  output logic [7:0]      out_addr_index,
  output logic            out_message_done,
  output logic [1:0]      out_status
);
  import sch_pkg::*;

  sch_item_t   in_item;
  sch_item_t   item;
  logic        item_valid;
  logic        res_ready;
  logic        advance;
  sch_result_t res;
  sch_result_t out_res;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // Move a byte through decode when the output register can take it
  assign advance = item_valid && res_ready;

  sch_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (res_ready),
    .item       (item)
  );

  sch_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  sch_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_role         = out_res.role;
  assign out_value        = out_res.value;
  assign out_addr_index   = out_res.addr_index;
  assign out_message_done = out_res.message_done;
  assign out_status       = out_res.status;

endmodule

`default_nettype wire
